// File: rtl/core/bfra_pkg.sv
// bfra_pkg: types, constants and status codes of the best-fit region allocator.
// Used by every module in rtl/core and by the bench; depends on nothing.
`timescale 1ns / 1ps
package bfra_pkg;
  localparam int MAX_PROCS = 127;
  localparam int MAX_HOLES = 128;
  localparam int ADDR_BITS = 16;
  localparam logic [15:0] MEM_RESET = 16'd4096;

  typedef enum logic [2:0] {
    ST_ALLOC = 3'd0,
    ST_FRAG  = 3'd1,
    ST_BIG   = 3'd2,
    ST_FREED = 3'd3,
    ST_NOID  = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] proc_id;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] region_start;
    logic [15:0] region_end;
    logic [15:0] total_free;
  } rsp_t;

  // owner entry carried along the owner cell chain
  typedef struct packed {
    logic                 valid;
    logic [15:0]          id;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] stop;
  } own_t;

  // hole entry carried along the hole cell chain
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] stop;
  } hole_t;
endpackage

// File: rtl/core/bfra_own_cell.sv
// bfra_own_cell: one owner table entry in the rotating owner chain.
// Depends on bfra_pkg.
`timescale 1ns / 1ps
module bfra_own_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          shift,
  input  bfra_pkg::own_t prev,
  output bfra_pkg::own_t cur
);
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cur.valid <= 1'b0;
    end else if (shift) begin
      cur <= prev;
    end
  end
endmodule

// File: rtl/core/bfra_hole_cell.sv
// bfra_hole_cell: one hole table entry in the rotating hole chain.
// Depends on bfra_pkg.
`timescale 1ns / 1ps
module bfra_hole_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clr,
  input  bfra_pkg::hole_t clr_val,
  input  logic           shift,
  input  bfra_pkg::hole_t prev,
  output bfra_pkg::hole_t cur
);
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cur <= clr_val;
    end else if (shift) begin
      cur <= prev;
    end
  end
endmodule

// File: rtl/core/best_fit_region_allocator.sv
// best_fit_region_allocator: top level, sequencer over the owner and hole cell chains.
// Depends on bfra_pkg, bfra_own_cell and bfra_hole_cell. A pass steps every cell once.
// Allocate: search pass, decision, update pass; free: search, decision, next-merge,
// prev-merge and insert passes; zero size, full table, no fitting hole or unknown id:
// search pass and decision. One request at a time; the next is taken in the cycle of the
// strobe. Reset and cfg writes set one free hole of that size if not 0; no output stall.
`timescale 1ns / 1ps
module best_fit_region_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           start,
  input  bfra_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output bfra_pkg::rsp_t rsp
);
  localparam int NP = bfra_pkg::MAX_PROCS;
  localparam int NH = bfra_pkg::MAX_HOLES;
  localparam int AW = bfra_pkg::ADDR_BITS;
  localparam int PASS = (NP > NH) ? NP : NH;
  localparam int CW = $clog2(PASS + 1);
  localparam int TW = AW + $clog2(NH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_OWN  = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_NEXT = 7'b0010000,
    S_PREV = 7'b0100000,
    S_INS  = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] cnt, own_pos, best_pos;
  logic kind;
  logic [15:0] pid, size;
  logic found_own, found_h, best_ok;
  logic [AW-1:0] best_len, best_st, best_en, s, e, new_end, h_len;
  logic [TW-1:0] total;

  bfra_pkg::own_t  own [NP];
  bfra_pkg::hole_t hl  [NH];
  bfra_pkg::own_t  own_wb;
  bfra_pkg::hole_t hole_wb, hole_init;
  logic [15:0] init_units;
  logic in_pass, own_shift, hole_shift, last, h_ok, fits, own_hit, hole_hit;

  assign init_units = rst ? bfra_pkg::MEM_RESET : cfg_wdata;
  assign hole_init = '{valid: init_units != 16'd0, start: '0, stop: AW'(init_units)};

  // cell 0 is the head; entries move one cell towards it per shift and the head,
  // possibly rewritten, re-enters at the tail, so a full pass restores the order
  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_own
      bfra_own_cell u_cell (
        .clk(clk), .rst(rst), .clr(cfg_we), .shift(own_shift),
        .prev((g == NP - 1) ? own_wb : own[(g + 1) % NP]), .cur(own[g]));
    end
    for (g = 0; g < NH; g++) begin : g_hole
      bfra_hole_cell u_cell (
        .clk(clk), .rst(rst), .clr(cfg_we),
        .clr_val((g == 0) ? hole_init : bfra_pkg::hole_t'('0)), .shift(hole_shift),
        .prev((g == NH - 1) ? hole_wb : hl[(g + 1) % NH]), .cur(hl[g]));
    end
  endgenerate

  assign in_pass = (state == S_OWN) || (state == S_UPD) || (state == S_NEXT) ||
                   (state == S_PREV) || (state == S_INS);
  assign last = cnt == CW'(PASS - 1);
  assign own_shift = in_pass && (cnt < CW'(NP));
  assign hole_shift = in_pass && (cnt < CW'(NH));
  assign new_end = AW'(best_st + AW'(size));
  assign h_len = hl[0].stop - hl[0].start;
  assign h_ok = hl[0].valid && hl[0].stop >= hl[0].start;
  assign fits = (size <= h_len) && (!best_ok || h_len < best_len ||
                (h_len == best_len && hl[0].start < best_st));
  assign own_hit = (state == S_OWN) && own_shift && !found_own &&
                   (kind ? (own[0].valid && own[0].id == pid) : !own[0].valid);

  always_comb begin
    unique case (state)
      S_NEXT:  hole_hit = hl[0].valid && hl[0].start == e;
      S_PREV:  hole_hit = hl[0].valid && hl[0].stop == s;
      S_INS:   hole_hit = !hl[0].valid;
      default: hole_hit = 1'b0;
    endcase
    hole_hit = hole_hit && hole_shift && !found_h;
  end

  // rewrite the head entry on its way to the tail
  always_comb begin
    own_wb = own[0];
    hole_wb = hl[0];
    if (own_hit && kind) own_wb.valid = 1'b0;
    if (state == S_UPD && cnt == own_pos) begin
      own_wb = '{valid: 1'b1, id: pid, start: best_st, stop: new_end};
    end
    if (state == S_UPD && cnt == best_pos) begin
      hole_wb.valid = (new_end != best_en);
      hole_wb.start = new_end;
    end
    if (hole_hit) begin
      if (state == S_INS) hole_wb = '{valid: 1'b1, start: s, stop: e};
      else hole_wb.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; done <= 1'b0; rsp <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            kind <= req.kind; pid <= req.proc_id; size <= req.request_size;
            found_own <= 1'b0; found_h <= 1'b0; best_ok <= 1'b0; total <= '0;
            state <= S_OWN;
          end
        end
        S_OWN: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (own_hit) begin
            found_own <= 1'b1; own_pos <= cnt;
            s <= own[0].start; e <= own[0].stop;
          end
          if (!kind && hole_shift && h_ok) begin
            total <= total + TW'(h_len);
            if (fits) begin
              best_ok <= 1'b1; best_len <= h_len; best_st <= hl[0].start;
              best_en <= hl[0].stop; best_pos <= cnt;
            end
          end
          if (last) state <= S_DEC;
        end
        S_DEC: begin
          cnt <= '0;
          if (kind) begin
            if (found_own) begin
              state <= S_NEXT;
            end else begin
              state <= S_IDLE; done <= 1'b1;
              rsp <= '{status: bfra_pkg::ST_NOID, default: '0};
            end
          end else if (size == 16'd0) begin
            state <= S_IDLE; done <= 1'b1;
            rsp <= '{status: bfra_pkg::ST_BIG, default: '0};
          end else if (!found_own) begin
            state <= S_IDLE; done <= 1'b1;
            rsp <= '{status: bfra_pkg::ST_FULL, default: '0};
          end else if (!best_ok) begin
            state <= S_IDLE; done <= 1'b1;
            rsp <= '{status: (total >= TW'(size)) ? bfra_pkg::ST_FRAG : bfra_pkg::ST_BIG,
                     region_start: '0, region_end: '0, total_free: total[15:0]};
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) begin
            state <= S_IDLE; done <= 1'b1;
            rsp <= '{status: bfra_pkg::ST_ALLOC, region_start: best_st,
                     region_end: new_end, total_free: total[15:0]};
          end
        end
        S_NEXT: begin
          cnt <= last ? '0 : cnt + 1'b1;
          found_h <= last ? 1'b0 : (found_h || hole_hit);
          if (hole_hit) e <= hl[0].stop;
          if (last) state <= S_PREV;
        end
        S_PREV: begin
          cnt <= last ? '0 : cnt + 1'b1;
          found_h <= last ? 1'b0 : (found_h || hole_hit);
          if (hole_hit) s <= hl[0].start;
          if (last) state <= S_INS;
        end
        S_INS: begin
          cnt <= last ? '0 : cnt + 1'b1;
          found_h <= last ? 1'b0 : (found_h || hole_hit);
          if (last) begin
            state <= S_IDLE; done <= 1'b1;
            rsp <= '{status: bfra_pkg::ST_FREED, region_start: s, region_end: e,
                     total_free: '0};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted request did not start");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(PASS - 1))
    else $error("pass counter out of range");
`endif
endmodule

// File: tb/tb_best_fit_region_allocator.sv
// tb_best_fit_region_allocator: self-checking bench for the best-fit region allocator.
// Drives allocate and free beats, predicts every response and checks it on the strobe.
// Depends on bfra_pkg and best_fit_region_allocator.
`timescale 1ns / 1ps
module tb_best_fit_region_allocator;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 600;

  class alloc_scoreboard;
    logic [15:0]     own_id [bfra_pkg::MAX_PROCS];
    logic [15:0]     own_lo [bfra_pkg::MAX_PROCS];
    logic [15:0]     own_hi [bfra_pkg::MAX_PROCS];
    bit              own_live [bfra_pkg::MAX_PROCS];
    logic [15:0]     hole_lo [bfra_pkg::MAX_HOLES];
    logic [15:0]     hole_hi [bfra_pkg::MAX_HOLES];
    bit              hole_live [bfra_pkg::MAX_HOLES];
    bfra_pkg::rsp_t  awaited [$];
    int              errors;
    int              checked;
    int              n_status [6];

    function void set_memory_size(logic [15:0] units);
      foreach (own_live[i]) own_live[i] = 0;
      foreach (hole_live[i]) begin
        hole_live[i] = 0;
        hole_lo[i] = '0;
        hole_hi[i] = '0;
      end
      hole_hi[0] = units;
      hole_live[0] = (units != 0);
    endfunction

    function bfra_pkg::rsp_t grant(bfra_pkg::req_t r);
      bfra_pkg::rsp_t o;
      int slot, best;
      logic [31:0] total;
      logic [15:0] blen, len, e;
      o = '0;
      slot = -1;
      best = -1;
      total = 0;
      blen = 0;
      if (r.request_size == 0) begin
        o.status = bfra_pkg::ST_BIG;
        return o;
      end
      for (int i = 0; i < bfra_pkg::MAX_PROCS; i++)
        if (!own_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        o.status = bfra_pkg::ST_FULL;
        return o;
      end
      for (int i = 0; i < bfra_pkg::MAX_HOLES; i++) begin
        if (hole_live[i] && hole_hi[i] >= hole_lo[i]) begin
          len = hole_hi[i] - hole_lo[i];
          total += len;
          if (r.request_size <= len &&
              (best < 0 || len < blen || (len == blen && hole_lo[i] < hole_lo[best]))) begin
            best = i;
            blen = len;
          end
        end
      end
      o.total_free = total[15:0];
      if (best < 0) begin
        o.status = (total >= r.request_size) ? bfra_pkg::ST_FRAG : bfra_pkg::ST_BIG;
        return o;
      end
      e = hole_lo[best] + r.request_size;
      own_id[slot] = r.proc_id;
      own_lo[slot] = hole_lo[best];
      own_hi[slot] = e;
      own_live[slot] = 1;
      o.status = bfra_pkg::ST_ALLOC;
      o.region_start = hole_lo[best];
      o.region_end = e;
      if (e == hole_hi[best]) hole_live[best] = 0;
      else hole_lo[best] = e;
      return o;
    endfunction

    function bfra_pkg::rsp_t release_region(bfra_pkg::req_t r);
      bfra_pkg::rsp_t o;
      int k, done_merge;
      logic [15:0] s, e;
      o = '0;
      k = -1;
      for (int i = 0; i < bfra_pkg::MAX_PROCS; i++)
        if (k < 0 && own_live[i] && own_id[i] == r.proc_id) k = i;
      if (k < 0) begin
        o.status = bfra_pkg::ST_NOID;
        return o;
      end
      s = own_lo[k];
      e = own_hi[k];
      own_live[k] = 0;
      done_merge = 0;
      for (int i = 0; i < bfra_pkg::MAX_HOLES; i++)
        if (!done_merge && hole_live[i] && hole_lo[i] == e) begin
          e = hole_hi[i];
          hole_live[i] = 0;
          done_merge = 1;
        end
      done_merge = 0;
      for (int i = 0; i < bfra_pkg::MAX_HOLES; i++)
        if (!done_merge && hole_live[i] && hole_hi[i] == s) begin
          s = hole_lo[i];
          hole_live[i] = 0;
          done_merge = 1;
        end
      done_merge = 0;
      for (int i = 0; i < bfra_pkg::MAX_HOLES; i++)
        if (!done_merge && !hole_live[i]) begin
          hole_lo[i] = s;
          hole_hi[i] = e;
          hole_live[i] = 1;
          done_merge = 1;
        end
      o.status = bfra_pkg::ST_FREED;
      o.region_start = s;
      o.region_end = e;
      return o;
    endfunction

    function void note_request(bfra_pkg::req_t r);
      bfra_pkg::rsp_t o;
      o = r.kind ? release_region(r) : grant(r);
      n_status[o.status]++;
      awaited.insert(awaited.size(), o);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(bfra_pkg::rsp_t got);
      bfra_pkg::rsp_t want;
      if (awaited.size() == 0) begin
        report("unexpected response status", 16'(got.status), 16'd0);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.status !== want.status)
        report("status", 16'(got.status), 16'(want.status));
      if (got.region_start !== want.region_start)
        report("region_start", got.region_start, want.region_start);
      if (got.region_end !== want.region_end)
        report("region_end", got.region_end, want.region_end);
      if (got.total_free !== want.total_free)
        report("total_free", got.total_free, want.total_free);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic start = 0;
  bfra_pkg::req_t req = '0;
  logic busy, done;
  bfra_pkg::rsp_t rsp;

  alloc_scoreboard sb;
  int idle_cycles = 0;
  int beats_sent = 0;

  best_fit_region_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .req(req), .busy(busy), .done(done), .rsp(rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done && sb != null) sb.check_result(rsp);
  end

  // count cycles with neither an accepted beat nor a response
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("best_fit_region_allocator verification failed");
      $finish;
    end
  end

  task automatic send(logic k, logic [15:0] pid, logic [15:0] size);
    int gap;
    bfra_pkg::req_t r;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    r.kind = k;
    r.proc_id = pid;
    r.request_size = size;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    beats_sent++;
  endtask

  task automatic write_size(logic [15:0] units);
    start <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= units;
    @(posedge clk);
    cfg_we <= 0;
    cfg_wdata <= 16'($urandom);
    sb.set_memory_size(units);
  endtask

  task automatic random_beat(logic [15:0] units, int free_pct);
    logic k;
    logic [15:0] pid, size;
    int sel;
    k = ($urandom_range(0, 99) < free_pct);
    pid = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 80) size = 16'($urandom_range(1, units / 8 + 1));
    else if (sel < 85) size = 0;
    else if (sel < 92) size = 16'($urandom);
    else size = units - 16'($urandom_range(0, 2));
    send(k, pid, size);
  endtask

  initial begin
    logic [15:0] sizes [5];
    sb = new();
    sb.set_memory_size(bfra_pkg::MEM_RESET);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, fragmentation, merges and missing ids
    send(0, 16'd1, 16'd1);
    send(1, 16'd1, 16'd0);
    send(0, 16'd2, 16'd4096);
    send(0, 16'd3, 16'd1);
    send(1, 16'd2, 16'hFFFF);
    send(0, 16'hFFFF, 16'd4097);
    send(0, 16'd4, 16'd0);
    send(0, 16'd5, 16'hFFFF);
    send(1, 16'hABCD, 16'd7);
    send(0, 16'd10, 16'd1000);
    send(0, 16'd11, 16'd1000);
    send(0, 16'd10, 16'd1000);
    send(1, 16'd10, 16'd0);
    send(0, 16'd12, 16'd1500);
    send(1, 16'd11, 16'd0);
    send(1, 16'd10, 16'd0);
    send(0, 16'd12, 16'd1500);
    write_size(16'd1);
    send(0, 16'd1, 16'd1);
    send(0, 16'd2, 16'd1);
    send(1, 16'd1, 16'd0);
    write_size(16'd0);
    send(0, 16'd1, 16'd1);
    send(1, 16'd1, 16'd0);

    // fill the owner table, then churn with frees
    write_size(16'hFFFF);
    for (int i = 0; i < 132; i++) send(0, 16'($urandom_range(0, 40)), 16'($urandom_range(1, 3)));
    for (int i = 0; i < 40; i++) random_beat(16'hFFFF, 70);

    sizes = '{16'hFFFF, 16'd100, 16'($urandom_range(2, 65534)), 16'd4096, 16'd1};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      for (int i = 0; i < 65; i++) random_beat(sizes[p], 40);
    end

    start <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats and checked %0d responses across nine memory size settings.",
             beats_sent, sb.checked);
    $display("Statuses: alloc %0d frag %0d big %0d freed %0d noid %0d full %0d",
             sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
             sb.n_status[4], sb.n_status[5]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("best_fit_region_allocator verification clean");
    end else begin
      $display("best_fit_region_allocator verification failed");
    end
    $finish;
  end
endmodule
